// ===== design/assert_macros.svh =====
// Assertion macros used by the deque engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, disabled while reset is high.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Clocked implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rde_pkg.sv =====
// Types and constants of the reversible deque engine.
package rde_pkg;

  localparam int VALUE_W  = 16;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REVERSE = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_FINISH  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEMENT  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_DELERR   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

endpackage

// ===== design/rde_store.sv =====
// Element store: one write port, one read port with registered read data.
module rde_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [rde_pkg::VALUE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [rde_pkg::VALUE_W-1:0]   rdata
);

  logic [rde_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/reversible_deque_engine.sv =====
// Reversible deque engine top level: command decode, ring pointers and drain sequencer.
//
// Double-ended queue of up to DEPTH 16-bit values in a ring store with a direction
// flag. Append, reverse and delete are accepted back to back, also while a result
// waits on the output. A finish that reports an error or an empty list yields one
// result and clears the state. A finish with N stored values drains them through the
// store's single read port, one value per cycle while the output is not stalled; each
// value appears on the output in the cycle after its read is issued, and no input is
// taken during the drain. Output stalls hold the read sequencer, since the store's read
// register doubles as the output data register. A finish is taken only once the output
// register is free or being emptied.
module reversible_deque_engine #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rde_pkg::VALUE_W-1:0]     s_tdata,   // [15:0] item_value
  input  logic [rde_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rde_pkg::VALUE_W-1:0]     m_tdata,   // [15:0] out_value
  output logic [rde_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
  output logic                            m_tlast
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rde_pkg::state_t  state, state_next;
  logic [PW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic             rev;
  logic             del_err;
  logic             ovf_err;

  logic             out_valid;
  logic             out_mem;
  logic             out_last;
  rde_pkg::status_t out_status;

  rde_pkg::action_t act;
  logic             accept;
  logic             finish_acc;
  logic             drain_start;
  logic             rd_en;
  logic             rd_last;
  logic             wr_en;
  logic [CW-1:0]    drain_off;
  logic [PW-1:0]    off;
  logic [PW:0]      ring_sum;
  logic [PW-1:0]    ring_addr;
  logic [PW-1:0]    head_inc;
  logic [rde_pkg::VALUE_W-1:0] rd_data;

  assign act = rde_pkg::action_t'(s_tuser);

  assign s_tready = (state == rde_pkg::S_IDLE) &&
                    (!out_valid || m_tready || act != rde_pkg::ACT_FINISH);
  assign accept      = s_tvalid && s_tready;
  assign finish_acc  = accept && act == rde_pkg::ACT_FINISH;
  assign drain_start = finish_acc && !del_err && !ovf_err && count != '0;

  assign rd_en   = (state == rde_pkg::S_DRAIN) && (!out_valid || m_tready);
  assign rd_last = idx == count - CW'(1);
  assign wr_en   = accept && act == rde_pkg::ACT_APPEND && !del_err &&
                   count < CW'(DEPTH);

  // ring index of head + offset, offset below DEPTH
  always_comb begin
    drain_off = rev ? (count - CW'(1) - idx) : idx;
    off       = (state == rde_pkg::S_DRAIN) ? PW'(drain_off) : PW'(count);
    ring_sum  = {1'b0, head} + {1'b0, off};
    if (ring_sum >= (PW+1)'(DEPTH)) begin
      ring_addr = PW'(ring_sum - (PW+1)'(DEPTH));
    end else begin
      ring_addr = PW'(ring_sum);
    end
    head_inc = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rde_pkg::S_IDLE: begin
        if (drain_start) state_next = rde_pkg::S_DRAIN;
      end
      rde_pkg::S_DRAIN: begin
        if (rd_en && rd_last) state_next = rde_pkg::S_IDLE;
      end
      default: state_next = rde_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rde_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      idx     <= '0;
      rev     <= 1'b0;
      del_err <= 1'b0;
      ovf_err <= 1'b0;
    end else if (finish_acc && !drain_start) begin
      head    <= '0;
      count   <= '0;
      rev     <= 1'b0;
      del_err <= 1'b0;
      ovf_err <= 1'b0;
    end else if (drain_start) begin
      idx <= '0;
    end else if (rd_en) begin
      idx <= idx + CW'(1);
      if (rd_last) begin
        head    <= '0;
        count   <= '0;
        rev     <= 1'b0;
        del_err <= 1'b0;
        ovf_err <= 1'b0;
      end
    end else if (accept && !del_err) begin
      unique case (act)
        rde_pkg::ACT_APPEND: begin
          if (count >= CW'(DEPTH)) begin
            ovf_err <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end
        rde_pkg::ACT_REVERSE: begin
          rev <= !rev;
        end
        rde_pkg::ACT_DELETE: begin
          if (count == '0) begin
            del_err <= 1'b1;
          end else begin
            if (!rev) head <= head_inc;
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register; element data sits in the store's read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en || (finish_acc && !drain_start)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_mem    <= 1'b1;
      out_last   <= rd_last;
      out_status <= rde_pkg::ST_ELEMENT;
    end else if (finish_acc && !drain_start) begin
      out_mem  <= 1'b0;
      out_last <= 1'b1;
      priority if (del_err) begin
        out_status <= rde_pkg::ST_DELERR;
      end else if (ovf_err) begin
        out_status <= rde_pkg::ST_OVERFLOW;
      end else begin
        out_status <= rde_pkg::ST_EMPTY;
      end
    end
  end

  rde_store #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ring_addr),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (ring_addr),
    .rdata (rd_data)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = out_mem ? rd_data : '0;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_bound, count <= CW'(DEPTH), "element count above depth")
  `ASSERT_IMP(a_drain_nonempty, state == rde_pkg::S_DRAIN, count != '0 && !s_tready, "drain state with empty store or open input")
  `ASSERT_NXT(a_read_shows, rd_en, out_valid && out_mem, "store read not presented at output")

endmodule
